// File: sv/interpolation_search_core_macros.svh
// Assertion macros shared by the interpolation search core modules.
`ifndef INTERPOLATION_SEARCH_CORE_MACROS_SVH
`define INTERPOLATION_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ISC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ISC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/isc_pkg.sv
// Package of the interpolation search core: sizes, codes and control word types.
`default_nettype none

package isc_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W       = ADDR_W + 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CNT_W       = (CFG_W > IDX_W) ? CFG_W : IDX_W;
  localparam int unsigned REM_W       = DATA_W + ADDR_W;
  localparam int unsigned DSH_W       = DATA_W + ADDR_W - 1;
  localparam int unsigned DCNT_W      = $clog2(ADDR_W + 1);
  localparam int unsigned STEP_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_LO,
    RD_HI,
    RD_J
  } rd_sel_e;

  typedef enum logic [1:0] {
    LAT_NONE,
    LAT_LO,
    LAT_HI,
    LAT_J
  } lat_sel_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_DIFF,
    OP_MUL,
    OP_DSTEP,
    OP_JCALC,
    OP_HIDOWN,
    OP_LOUP,
    OP_LOEQ,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NZERO,
    C_NOLOOP,
    C_CNTNZ,
    C_KEYGT,
    C_KEYEQ,
    C_JZERO
  } cond_e;

  typedef struct packed {
    rd_sel_e             rd;
    lat_sel_e            lat;
    op_e                 op;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
    logic                last;
  } isc_ctl_t;

  typedef struct packed {
    logic n_zero;
    logic loop_ok;
    logic cnt_nz;
    logic key_gt;
    logic key_eq;
    logic j_zero;
  } isc_flags_t;

  localparam isc_ctl_t CTL_NOP = '{
    rd: RD_NONE, lat: LAT_NONE, op: OP_NOP, cond: C_NEVER, target: '0, last: 1'b0
  };

endpackage

`default_nettype wire

// File: sv/interpolation_search_core.sv
// Top level of the interpolation search core: ports, table memory and result register.
//
//   Channel   Direction  Handshake               Payload
//   in        request    in_valid_i / in_stall_o   req_type, entry_address, entry_value,
//                                                  search_key
//   out       result     out_valid_o / out_stall_i found, position
//   cfg       write      cfg_valid_i / cfg_ready_o cfg_data_i (entries_in_use)
//
// A write request is stored in the table in the cycle it is taken and gives no result.
// A search stalls the input until it finishes; each probe passes through the bit-serial
// divider, and the table port allows one read per cycle.
// Reset clears the sequencer and the result valid flag and sets entries_in_use to 1024;
// the table contents are undefined until written.
// A search that finishes while the result register is still full waits in its last step.
`default_nettype none

module interpolation_search_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [isc_pkg::ADDR_W-1:0]         entry_address_i,
  input  logic signed [isc_pkg::DATA_W-1:0]  entry_value_i,
  input  logic signed [isc_pkg::DATA_W-1:0]  search_key_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic [isc_pkg::ADDR_W-1:0]         position_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [isc_pkg::CFG_W-1:0]          cfg_data_i
);
  import isc_pkg::*;

  logic              busy;
  logic              in_take;
  logic              start;
  logic              wr_en;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  logic [CFG_W-1:0]  entries_q;
  logic [CNT_W-1:0]  cfg_ext;
  logic [IDX_W-1:0]  nsat;
  isc_ctl_t          ctl;
  isc_flags_t        flags;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !in_stall_o;
  assign start      = in_take && (req_type_i == REQ_SEARCH);
  assign wr_en      = in_take && (req_type_i == REQ_WRITE);

  assign cfg_ready_o = 1'b1;

  // A count above the table depth covers the whole table.
  assign cfg_ext = CNT_W'(entries_q);
  assign nsat    = (cfg_ext > CNT_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH) : IDX_W'(cfg_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= cfg_data_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.op == OP_FINISH) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  isc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (entry_address_i),
    .wdata_i (entry_value_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  isc_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .flags_i    (flags),
    .busy_o     (busy),
    .ctl_o      (ctl)
  );

  isc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .key_i      (search_key_i),
    .nsat_i     (nsat),
    .ctl_i      (ctl),
    .rd_data_i  (rd_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .flags_o    (flags),
    .found_o    (found_o),
    .position_o (position_o)
  );

endmodule

`default_nettype wire

// File: sv/isc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module isc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/isc_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
`include "interpolation_search_core_macros.svh"

module isc_useq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               out_free_i,
  input  isc_pkg::isc_flags_t flags_i,
  output logic               busy_o,
  output isc_pkg::isc_ctl_t  ctl_o
);
  import isc_pkg::*;

  localparam logic [STEP_W-1:0] S_INIT   = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_RDLO   = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_RDHI   = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_LATHI  = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_TEST   = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_MUL    = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_DIV    = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_JCALC  = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_RDJ    = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_LATJ   = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_CMPGT  = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_CMPEQ  = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_DOWN   = STEP_W'(12);
  localparam logic [STEP_W-1:0] S_RDHI2  = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_UP     = STEP_W'(14);
  localparam logic [STEP_W-1:0] S_RDLO2  = STEP_W'(15);
  localparam logic [STEP_W-1:0] S_LATLO2 = STEP_W'(16);
  localparam logic [STEP_W-1:0] S_EQ     = STEP_W'(17);
  localparam logic [STEP_W-1:0] S_FIN    = STEP_W'(18);

  function automatic isc_ctl_t mk(rd_sel_e rd, lat_sel_e lat, op_e op, cond_e cond,
                                  logic [STEP_W-1:0] target, logic last);
    isc_ctl_t w;
    w.rd     = rd;
    w.lat    = lat;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] pc_q, pc_d;
  isc_ctl_t          word;
  logic              take;
  logic              hold;

  // Control store. Reads of the table are latched in the step after the request.
  always_comb begin
    unique case (pc_q)
      S_INIT:   word = mk(RD_NONE, LAT_NONE, OP_INIT,   C_NZERO,  S_FIN,   1'b0);
      S_RDLO:   word = mk(RD_LO,   LAT_NONE, OP_NOP,    C_NEVER,  S_INIT,  1'b0);
      S_RDHI:   word = mk(RD_HI,   LAT_LO,   OP_NOP,    C_NEVER,  S_INIT,  1'b0);
      S_LATHI:  word = mk(RD_NONE, LAT_HI,   OP_NOP,    C_NEVER,  S_INIT,  1'b0);
      S_TEST:   word = mk(RD_NONE, LAT_NONE, OP_DIFF,   C_NOLOOP, S_FIN,   1'b0);
      S_MUL:    word = mk(RD_NONE, LAT_NONE, OP_MUL,    C_NEVER,  S_INIT,  1'b0);
      S_DIV:    word = mk(RD_NONE, LAT_NONE, OP_DSTEP,  C_CNTNZ,  S_DIV,   1'b0);
      S_JCALC:  word = mk(RD_NONE, LAT_NONE, OP_JCALC,  C_NEVER,  S_INIT,  1'b0);
      S_RDJ:    word = mk(RD_J,    LAT_NONE, OP_NOP,    C_NEVER,  S_INIT,  1'b0);
      S_LATJ:   word = mk(RD_NONE, LAT_J,    OP_NOP,    C_NEVER,  S_INIT,  1'b0);
      S_CMPGT:  word = mk(RD_NONE, LAT_NONE, OP_NOP,    C_KEYGT,  S_UP,    1'b0);
      S_CMPEQ:  word = mk(RD_NONE, LAT_NONE, OP_NOP,    C_KEYEQ,  S_EQ,    1'b0);
      S_DOWN:   word = mk(RD_NONE, LAT_NONE, OP_HIDOWN, C_JZERO,  S_FIN,   1'b0);
      S_RDHI2:  word = mk(RD_HI,   LAT_NONE, OP_NOP,    C_ALWAYS, S_LATHI, 1'b0);
      S_UP:     word = mk(RD_NONE, LAT_NONE, OP_LOUP,   C_NEVER,  S_INIT,  1'b0);
      S_RDLO2:  word = mk(RD_LO,   LAT_NONE, OP_NOP,    C_NEVER,  S_INIT,  1'b0);
      S_LATLO2: word = mk(RD_NONE, LAT_LO,   OP_NOP,    C_ALWAYS, S_TEST,  1'b0);
      S_EQ:     word = mk(RD_NONE, LAT_NONE, OP_LOEQ,   C_ALWAYS, S_FIN,   1'b0);
      default:  word = mk(RD_NONE, LAT_NONE, OP_FINISH, C_NEVER,  S_INIT,  1'b1);
    endcase
  end

  always_comb begin
    unique case (word.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_NZERO:  take = flags_i.n_zero;
      C_NOLOOP: take = !flags_i.loop_ok;
      C_CNTNZ:  take = flags_i.cnt_nz;
      C_KEYGT:  take = flags_i.key_gt;
      C_KEYEQ:  take = flags_i.key_eq;
      C_JZERO:  take = flags_i.j_zero;
      default:  take = 1'b0;
    endcase
  end

  // The closing step waits until the result register can take the answer.
  assign hold = word.last && !out_free_i;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    ctl_o  = CTL_NOP;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = S_INIT;
      end
    end else if (!hold) begin
      ctl_o = word;
      if (word.last) begin
        busy_d = 1'b0;
      end else if (take) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= S_INIT;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o = busy_q;

  `ISC_ASSERT_IMP(a_pc_range, busy_q, pc_q <= S_FIN, "step counter outside the program")
  `ISC_ASSERT_NXT(a_fin_hold, busy_q && word.last && !out_free_i, busy_q && pc_q == $past(pc_q), "closing step left while the result register was full")

endmodule

`default_nettype wire

// File: sv/isc_dp.sv
// Datapath of the interpolation search: bounds, probe arithmetic and divider.
`default_nettype none
`include "interpolation_search_core_macros.svh"

module isc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [isc_pkg::DATA_W-1:0]  key_i,
  input  logic [isc_pkg::IDX_W-1:0]          nsat_i,
  input  isc_pkg::isc_ctl_t                  ctl_i,
  input  logic [isc_pkg::DATA_W-1:0]         rd_data_i,
  output logic                               rd_en_o,
  output logic [isc_pkg::ADDR_W-1:0]         rd_addr_o,
  output isc_pkg::isc_flags_t                flags_o,
  output logic                               found_o,
  output logic [isc_pkg::ADDR_W-1:0]         position_o
);
  import isc_pkg::*;

  logic signed [DATA_W-1:0] key_q;
  logic signed [DATA_W-1:0] tlo_q, thi_q, tj_q;
  logic [IDX_W-1:0]         lo_q;
  logic [ADDR_W-1:0]        hi_q, j_q, span_q, q_q;
  logic [DATA_W-1:0]        num_q, den_q;
  logic [REM_W-1:0]         rem_q;
  logic [DSH_W-1:0]         dsh_q;
  logic [DCNT_W-1:0]        cnt_q;
  logic                     found_q;
  logic [ADDR_W-1:0]        pos_q;

  logic [DATA_W:0]   kdiff, tdiff;
  logic [REM_W-1:0]  prod;
  logic              ge;
  logic [ADDR_W:0]   jsum;
  logic              hit;

  assign kdiff = {key_q[DATA_W-1], key_q} - {tlo_q[DATA_W-1], tlo_q};
  assign tdiff = {thi_q[DATA_W-1], thi_q} - {tlo_q[DATA_W-1], tlo_q};
  assign prod  = num_q * span_q;
  assign ge    = rem_q >= REM_W'(dsh_q);
  assign jsum  = {1'b0, lo_q[ADDR_W-1:0]} + {1'b0, q_q};
  assign hit   = (lo_q < nsat_i) && (tlo_q == key_q);

  assign flags_o.n_zero  = (nsat_i == '0);
  assign flags_o.loop_ok = (lo_q <= {1'b0, hi_q}) && (thi_q >= key_q) && (key_q > tlo_q);
  assign flags_o.cnt_nz  = (cnt_q != '0);
  assign flags_o.key_gt  = key_q > tj_q;
  assign flags_o.key_eq  = key_q == tj_q;
  assign flags_o.j_zero  = (j_q == '0);

  assign rd_en_o = (ctl_i.rd != RD_NONE);

  always_comb begin
    unique case (ctl_i.rd)
      RD_LO:   rd_addr_o = lo_q[ADDR_W-1:0];
      RD_HI:   rd_addr_o = hi_q;
      RD_J:    rd_addr_o = j_q;
      default: rd_addr_o = hi_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end

    unique case (ctl_i.lat)
      LAT_LO:  tlo_q <= rd_data_i;
      LAT_HI:  thi_q <= rd_data_i;
      LAT_J:   tj_q  <= rd_data_i;
      default: ;
    endcase

    unique case (ctl_i.op)
      OP_INIT: begin
        lo_q <= '0;
        hi_q <= ADDR_W'(nsat_i - 1'b1);
      end
      OP_DIFF: begin
        // Both differences are non-negative and below 2^32 whenever the probe runs.
        num_q  <= kdiff[DATA_W-1:0];
        den_q  <= tdiff[DATA_W-1:0];
        span_q <= hi_q - lo_q[ADDR_W-1:0];
      end
      OP_MUL: begin
        rem_q <= prod;
        dsh_q <= {den_q, {(ADDR_W-1){1'b0}}};
        cnt_q <= DCNT_W'(ADDR_W - 1);
        q_q   <= '0;
      end
      OP_DSTEP: begin
        // Restoring division, one quotient bit per step; the quotient fits the span.
        rem_q <= ge ? (rem_q - REM_W'(dsh_q)) : rem_q;
        q_q   <= ADDR_W'({q_q, ge});
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      OP_JCALC: begin
        j_q <= (jsum > {1'b0, hi_q}) ? hi_q : jsum[ADDR_W-1:0];
      end
      OP_HIDOWN: begin
        hi_q <= j_q - 1'b1;
      end
      OP_LOUP: begin
        lo_q <= {1'b0, j_q} + 1'b1;
      end
      OP_LOEQ: begin
        lo_q  <= {1'b0, j_q};
        tlo_q <= tj_q;
      end
      OP_FINISH: begin
        found_q <= hit;
        pos_q   <= hit ? lo_q[ADDR_W-1:0] : '0;
      end
      default: ;
    endcase
  end

  assign found_o    = found_q;
  assign position_o = pos_q;

  `ISC_ASSERT_IMP(a_div_bound, ctl_i.op == OP_DSTEP, rem_q < {dsh_q, 1'b0}, "partial remainder too large for the quotient width")
  `ISC_ASSERT_IMP(a_quot_span, ctl_i.op == OP_JCALC, q_q <= span_q, "probe offset beyond the search span")

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the interpolation search core.
`timescale 1ns / 1ps

module tb;
  import isc_pkg::*;

  localparam int RANDOM_ITEMS   = 600;
  localparam int MAX_IDLE       = 19;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int VALUE_MIN      = 32'h8000_0000;
  localparam int VALUE_MAX      = 32'h7fff_ffff;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } lookup_result_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic                      req_type_i      = REQ_WRITE;
  logic [ADDR_W-1:0]         entry_address_i = '0;
  logic signed [DATA_W-1:0]  entry_value_i   = '0;
  logic signed [DATA_W-1:0]  search_key_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic                      found_o;
  logic [ADDR_W-1:0]         position_o;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_W-1:0]          cfg_data_i      = '0;

  // Shadow copy of the block's table and entry count.
  int shadow_table [TABLE_DEPTH];
  int shadow_entries = 1024;

  lookup_result_t pending_lookups [$];

  int src_idle_max  = 0;
  int sink_idle_max = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int n_errors      = 0;
  int n_writes      = 0;
  int n_searches    = 0;
  int n_hits        = 0;
  int n_settings    = 0;

  interpolation_search_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .entry_address_i (entry_address_i),
    .entry_value_i   (entry_value_i),
    .search_key_i    (search_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .position_o      (position_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Interpolation search over the shadow table, with the probe as an exact
  // truncated quotient.
  function automatic lookup_result_t predict_lookup(input int key);
    lookup_result_t res;
    longint n, lo, hi, j, num, den;
    res = '0;
    n = shadow_entries;
    if (n == 0) return res;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    lo = 0;
    hi = n - 1;
    while (lo <= hi && shadow_table[hi] >= key && key > shadow_table[lo]) begin
      num = longint'(key) - longint'(shadow_table[lo]);
      den = longint'(shadow_table[hi]) - longint'(shadow_table[lo]);
      j = lo + (num * (hi - lo)) / den;
      if (j > hi) j = hi;
      if (key > shadow_table[j]) begin
        lo = j + 1;
      end else if (key < shadow_table[j]) begin
        if (j == 0) break;
        hi = j - 1;
      end else begin
        lo = j;
        break;
      end
    end
    if (lo < n && shadow_table[lo] == key) begin
      res.found = 1'b1;
      res.position = lo[ADDR_W-1:0];
    end
    return res;
  endfunction

  // Mostly keys that sit in the table or right next to an entry.
  function automatic int pick_key(input int n_eff);
    int idx;
    if (n_eff == 0) return $urandom;
    idx = $urandom_range(0, n_eff - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return shadow_table[idx];
      5:             return shadow_table[idx] + 1;
      6:             return shadow_table[idx] - 1;
      7, 8:          return $urandom;
      default:       return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: MISMATCH %s", $time, what);
    n_errors++;
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin src_idle_max = 0;        sink_idle_max = 0;        end
      1: begin src_idle_max = MAX_IDLE; sink_idle_max = 0;        end
      2: begin src_idle_max = 0;        sink_idle_max = MAX_IDLE; end
      default: begin src_idle_max = MAX_IDLE; sink_idle_max = MAX_IDLE; end
    endcase
  endtask

  // Valid stays high after a request is taken, so back-to-back requests never
  // lower and raise it in the same step.
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                              input int value, input int key);
    int gap;
    lookup_result_t res;
    gap = $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    entry_address_i <= addr;
    entry_value_i   <= value;
    search_key_i    <= key;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == REQ_WRITE) begin
      shadow_table[addr] = value;
      n_writes++;
    end else begin
      res = predict_lookup(key);
      pending_lookups.push_back(res);
      n_searches++;
      if (res.found) n_hits++;
    end
  endtask

  task automatic send_write(input int addr, input int value);
    send_request(REQ_WRITE, addr[ADDR_W-1:0], value, $urandom);
  endtask

  task automatic send_search(input int key);
    send_request(REQ_SEARCH, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, key);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_entries(input int n);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_entries = n[CFG_W-1:0];
    n_settings++;
  endtask

  // Fills the whole table in order and searches at the reset entry count,
  // then with a count above the table depth.
  task automatic test_full_table();
    int vals [$];
    for (int i = 0; i < TABLE_DEPTH; i++) vals.push_back($urandom);
    vals.sort();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i % 128 == 0) pick_idling();
      send_write(i, vals[i]);
    end
    repeat (40) send_search(pick_key(TABLE_DEPTH));
    set_entries(2047);
    repeat (10) send_search(pick_key(TABLE_DEPTH));
  endtask

  task automatic test_directed();
    pick_idling();
    set_entries(4);
    send_write(0, VALUE_MIN);
    send_write(1, -5);
    send_write(2, 7);
    send_write(3, VALUE_MAX);
    send_write(TABLE_DEPTH - 1, 0);
    send_search(VALUE_MIN);
    send_search(VALUE_MAX);
    send_search(7);
    send_search(6);
    send_search(0);
    // With no entries in use every search misses.
    set_entries(0);
    send_search(7);
    set_entries(1);
    send_search(VALUE_MIN);
    send_search(5);
    // An unsorted table still has to give the same steps' answer.
    set_entries(4);
    send_write(1, 100);
    send_write(2, -100);
    send_search(-100);
    send_search(100);
    send_search(50);
  endtask

  // Phases of a random entry count: a fresh table prefix of up to 48 entries, at times
  // none, then searches with the odd stray write in between.
  task automatic test_random_phases();
    int start, n, n_eff, w, style, base;
    int vals [$];
    int order [$];
    start = n_writes + n_searches;
    while (n_writes + n_searches - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       n = 0;
        1:       n = $urandom_range(TABLE_DEPTH + 1, 2047);
        2:       n = TABLE_DEPTH;
        3:       n = $urandom_range(49, TABLE_DEPTH - 1);
        default: n = $urandom_range(1, 48);
      endcase
      pick_idling();
      set_entries(n);
      n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      if (n_eff > 48) w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 48);
      else w = n_eff;
      style = $urandom_range(0, 9);
      base = $urandom;
      vals.delete();
      order.delete();
      for (int i = 0; i < w; i++) begin
        vals.push_back(style == 1 ? base + int'($urandom_range(0, 15)) : int'($urandom));
        order.push_back(i);
      end
      if (style != 0) vals.sort();
      order.shuffle();
      foreach (order[i]) send_write(order[i], vals[order[i]]);
      if (n_eff < TABLE_DEPTH && $urandom_range(0, 3) == 0)
        send_write($urandom_range(n_eff, TABLE_DEPTH - 1), $urandom);
      repeat ($urandom_range(3, 16)) begin
        if ($urandom_range(0, 9) == 0) send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        else send_search(pick_key(n_eff));
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with no search pending");
      end else begin
        want = pending_lookups.pop_front();
        if (found_o !== want.found)
          report_mismatch($sformatf("found: got %b, expected %b", found_o, want.found));
        if (position_o !== want.position)
          report_mismatch($sformatf("position: got %0d, expected %0d",
                                    position_o, want.position));
      end
      stall_left = $urandom_range(0, sink_idle_max);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_full_table();
    test_directed();
    test_random_phases();
    wait_idle();
    if (pending_lookups.size() != 0)
      report_mismatch($sformatf("%0d searches never answered", pending_lookups.size()));
    $display("Covered %0d table writes and %0d searches (%0d found) over %0d entry counts.",
             n_writes, n_searches, n_hits, n_settings);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/isc_pkg.sv
sv/isc_ram.sv
sv/isc_useq.sv
sv/isc_dp.sv
sv/interpolation_search_core.sv
test/tb.sv
